[hdl/fxu_pkg.sv]
// Package for the 16.16 fixed-point unit: operation codes, status codes, widths.
// Used by fixed_point_16_16_unit and fxu_core.
package fxu_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DATA_W = 32;
	localparam int THR_W = 16;
	localparam int LIM_W = 8;
	localparam logic [THR_W-1:0] THR_RESET = 16'd6;
	localparam logic [LIM_W-1:0] LIM_RESET = 8'd64;

	typedef enum logic [2:0] {
		OP_MUL = 3'd0, OP_DIV = 3'd1, OP_ABS = 3'd2,
		OP_F2X = 3'd3, OP_SQRT = 3'd4, OP_CBRT = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_NOCONV = 2'd2, ST_OVF = 2'd3
	} status_t;

	localparam logic REG_THR = 1'b0;
	localparam logic REG_LIM = 1'b1;
endpackage

[hdl/fixed_point_16_16_unit.sv]
// Top level of the 16.16 fixed-point unit: stream ports, config registers,
// output register. Depends on fxu_pkg and fxu_core.
//
// Usage: one request transfer on s_axis gives one result transfer on m_axis.
// s_axis_tdata: req_type[2:0], operand_a[34:3], operand_b[66:35], zero-padded.
// m_axis_tdata: result[31:0], status[33:32], zero-padded.
// Abs, float conversion and unused codes finish from the idle state; multiply
// uses the product register; divide takes one quotient bit per cycle over a
// 48-bit dividend; roots take one divider pass per Newton iteration, up to
// iteration_limit iterations, all on the one shared divider.
// One request is in flight at a time; s_axis_tready is low while the unit
// works or while a result waits in the output register.
// If the receiver stalls, the result is held until taken.
// Reset clears the sequencer and sets stop_threshold 6, iteration_limit 64.
// Config writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and are
// meant for idle periods.
module fixed_point_16_16_unit #(
	parameter int FRAC_BITS = fxu_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // req_type, operand_a, operand_b
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // result, status
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_wdata
);
	import fxu_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic [LIM_W-1:0]  lim_q;
	logic              busy_q, ovalid_q;
	logic [DATA_W-1:0] ores_q;
	logic [1:0]        ost_q;
	logic              cdone;
	logic [DATA_W-1:0] cres;
	logic [1:0]        cst;
	logic              take;

	assign s_axis_tready = !busy_q && !ovalid_q;
	assign take = s_axis_tvalid && s_axis_tready;

	fxu_core #(.FRAC_BITS(FRAC_BITS)) u_core (
		.clk(clk), .arst_n(arst_n), .start(take),
		.op(s_axis_tdata[2:0]), .a(s_axis_tdata[34:3]), .b(s_axis_tdata[66:35]),
		.thr(thr_q), .lim(lim_q), .done(cdone), .res(cres), .st(cst)
	);

	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			lim_q <= LIM_RESET;
		end else if (cfg_we) begin
			if (cfg_addr == REG_THR) thr_q <= cfg_wdata;
			else lim_q <= cfg_wdata[LIM_W-1:0];
		end
	end

	// Busy flag and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (take) busy_q <= 1'b1;
			if (cdone) begin
				busy_q   <= 1'b0;
				ovalid_q <= 1'b1;
				ores_q   <= cres;
				ost_q    <= cst;
			end else if (ovalid_q && m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'b0, ost_q, ores_q};
endmodule

[hdl/fxu_divider.sv]
// Shared restoring divider, one quotient bit per cycle, unsigned magnitudes.
// Depends on no other module or package.
module fxu_divider #(
	parameter int NUM_W = 48,
	parameter int DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;

	always_comb begin
		trial = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	end

	// Shift-subtract loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
				quo_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
			end else if (busy_q) begin
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					quo_q <= {quo_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					quo_q <= {quo_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quo = quo_q;
endmodule

[hdl/fxu_core.sv]
// Sequencer for the fixed-point unit: multiply and cube root share prod_q,
// divide and both roots share one divider. Depends on fxu_pkg and fxu_divider.
module fxu_core #(
	parameter int FRAC_BITS = fxu_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [2:0]                 op,
	input  logic [fxu_pkg::DATA_W-1:0] a,
	input  logic [fxu_pkg::DATA_W-1:0] b,
	input  logic [fxu_pkg::THR_W-1:0]  thr,
	input  logic [fxu_pkg::LIM_W-1:0]  lim,
	output logic                       done,
	output logic [fxu_pkg::DATA_W-1:0] res,
	output logic [1:0]                 st
);
	import fxu_pkg::*;
	localparam int NUM_W = DATA_W + FRAC_BITS;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIV, S_RDEN, S_RMUL, S_RDIV, S_RSTEP
	} state_t;

	state_t state_q;
	logic [2:0]        op_q;
	logic [DATA_W-1:0] a_q, t_q, den_q, diff_q;
	logic [LIM_W-1:0]  k_q;
	logic              neg_q;
	logic              dstart;
	logic [NUM_W-1:0]  dnum;
	logic [DATA_W-1:0] dden;
	logic              ddone;
	logic [NUM_W-1:0]  dquo;
	logic signed [2*DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] mul_res;
	logic [DATA_W-1:0] q_signed, diff, dt, t_next, dt_mag;
	logic [DATA_W:0]   div3;
	logic [LIM_W-1:0]  lim_eff;
	logic [DATA_W-1:0] f2x_r;
	logic [1:0]        f2x_st;
	logic signed [9:0] f2x_e;
	logic [23:0]       mant;

	fxu_divider #(.NUM_W(NUM_W), .DEN_W(DATA_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dquo)
	);

	// Divider operands: magnitudes of a and of the current divisor
	always_comb begin
		dnum = {(a_q[DATA_W-1] ? -a_q : a_q), {FRAC_BITS{1'b0}}};
		dden = den_q[DATA_W-1] ? -den_q : den_q;
	end

	// Truncated product and quotient sign fix
	assign mul_res  = prod_q[FRAC_BITS +: DATA_W];
	assign q_signed = neg_q ? -dquo[DATA_W-1:0] : dquo[DATA_W-1:0];

	// Raw Newton difference, registered when the divider finishes
	assign diff = q_signed - t_q;

	// Newton step, truncated toward zero
	always_comb begin
		logic [DATA_W-1:0]   m;
		logic [DATA_W-1:0]   h;
		logic [2*DATA_W+1:0] p3;
		m    = diff_q[DATA_W-1] ? -diff_q : diff_q;
		p3   = (2*DATA_W+2)'(m) * 66'h0_AAAA_AAAB;
		div3 = p3[2*DATA_W+1:DATA_W+1];
		h    = (op_q == OP_CBRT) ? div3[DATA_W-1:0] : (m >> 1);
		dt   = diff_q[DATA_W-1] ? -h : h;
		dt_mag = dt[DATA_W-1] ? -dt : dt;
		t_next = t_q + dt;
	end

	assign lim_eff = (lim == '0) ? LIM_W'(1) : lim;

	// Float bits to fixed point
	always_comb begin
		logic [DATA_W-1:0] r;
		mant  = {1'b1, a[22:0]};
		f2x_e = $signed({2'b0, a[30:23]}) - 10'sd127 + 10'(FRAC_BITS);
		f2x_st = ST_OK;
		r = '0;
		if (f2x_e < 0) r = '0;
		else if (f2x_e <= 23) r = DATA_W'(mant >> (5'd23 - f2x_e[4:0]));
		else if (f2x_e < 31) r = DATA_W'({8'b0, mant} << (f2x_e[4:0] - 5'd23));
		else f2x_st = ST_OVF;
		if (f2x_st == ST_OVF) f2x_r = '0;
		else f2x_r = a[31] ? -r : r;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			dstart  <= 1'b0;
		end else begin
			done   <= 1'b0;
			dstart <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					op_q <= op; a_q <= a;
					t_q  <= DATA_W'(2) << FRAC_BITS;
					k_q  <= '0;
					unique case (op)
						OP_MUL: begin
							prod_q <= $signed(a) * $signed(b);
							state_q <= S_MUL;
						end
						OP_DIV: begin
							if (b == '0) begin
								res <= '0; st <= ST_DIV0; done <= 1'b1;
							end else begin
								den_q <= b; neg_q <= a[31] ^ b[31];
								dstart <= 1'b1; state_q <= S_DIV;
							end
						end
						OP_ABS: begin
							res <= a[31] ? -a : a; st <= ST_OK; done <= 1'b1;
						end
						OP_F2X: begin
							res <= f2x_r; st <= f2x_st; done <= 1'b1;
						end
						OP_SQRT, OP_CBRT: state_q <= S_RDEN;
						default: begin
							res <= '0; st <= ST_OK; done <= 1'b1;
						end
					endcase
				end
				S_MUL: begin
					res <= mul_res; st <= ST_OK; done <= 1'b1; state_q <= S_IDLE;
				end
				S_DIV: if (ddone) begin
					res <= q_signed; st <= ST_OK; done <= 1'b1; state_q <= S_IDLE;
				end
				S_RDEN: begin
					if (op_q == OP_CBRT) begin
						prod_q <= $signed(t_q) * $signed(t_q);
						state_q <= S_RMUL;
					end else if (t_q == '0) begin
						res <= '0; st <= ST_DIV0; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						den_q <= t_q; neg_q <= a_q[31] ^ t_q[31];
						dstart <= 1'b1; state_q <= S_RDIV;
					end
				end
				S_RMUL: begin
					if (mul_res == '0) begin
						res <= '0; st <= ST_DIV0; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						den_q <= mul_res; neg_q <= a_q[31] ^ mul_res[31];
						dstart <= 1'b1; state_q <= S_RDIV;
					end
				end
				S_RDIV: if (ddone) begin
					diff_q  <= diff;
					state_q <= S_RSTEP;
				end
				S_RSTEP: begin
					t_q <= t_next;
					k_q <= k_q + 1'b1;
					if (dt_mag <= DATA_W'(thr)) begin
						res <= t_next; st <= ST_OK; done <= 1'b1; state_q <= S_IDLE;
					end else if (k_q + 1'b1 >= lim_eff) begin
						res <= t_next; st <= ST_NOCONV; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						state_q <= S_RDEN;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[hdl/fxu_checker.sv]
// Port-level checker for the fixed-point unit, bound to the top level.
// Depends on fixed_point_16_16_unit.
module fxu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	// No new request while a result waits
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept with pending result");
	// Result held under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	// Accept makes the unit busy next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("not busy");
	// Padding bits are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:34] == 6'd0) else $error("pad bits");
endmodule

bind fixed_point_16_16_unit fxu_checker u_fxu_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
